// File: rtl/prcc_pkg.sv
`default_nettype none
package prcc_pkg;

    localparam int PRCC_PAGE_BYTES = 4096;
    localparam int PRCC_SLOT_BYTES = 64 * 1024;
    localparam int PRCC_BATCH_MAX  = 65536;

    localparam int ROW_ID_W = 40;
    localparam int ROWS_W   = 41;
    localparam int OFFSET_W = 43;
    localparam int BYTE_W   = 44;   // byte addresses up to and including 2^43
    localparam int LENGTH_W = 29;
    localparam int POS_W    = 16;
    localparam int COUNT_W  = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [ROWS_W-1:0]   COLUMN_ROWS_RESET = '0;
    localparam logic [LENGTH_W-1:0] MAX_RANGE_RESET   = LENGTH_W'(8 << 20);

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN_ROWS = 2'd0,
        CFG_MAX_RANGE   = 2'd1
    } t_cfg_idx;

    // One classified row: its page-aligned, clipped span and batch bookkeeping.
    typedef struct packed {
        logic [OFFSET_W-1:0] pbeg;
        logic [BYTE_W-1:0]   pend;
        logic [POS_W-1:0]    pos;
        logic                last;
    } t_span;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [LENGTH_W-1:0] byte_length;
        logic [POS_W-1:0]    first_position;
        logic [COUNT_W-1:0]  rows_covered;
        logic                fits_slot;
        logic                final_range;
    } t_range;

endpackage
`default_nettype wire

// File: rtl/page_read_range_coalescer_unit.sv
`default_nettype none
// Channel   Direction  Transfer when              Payload
// input     in         push & !full               i_row_id, i_batch_end
// result    out        pop & !empty               o_byte_offset .. o_final_range
// config    in         i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// One row id per cycle sustained while the back is not held. The front classifies
// a row in the cycle it is taken and writes it into a two-entry queue; the back
// folds one queued row per cycle into the open range and may write up to two
// ranges into a four-entry result queue. A range passes through the middle queue
// and the result queue before it shows on the result ports. The back holds while
// the result queue has fewer than two free entries; full rises when the middle
// queue fills. Reset is synchronous, empties both queues and closes the open range.
module page_read_range_coalescer_unit #(
    parameter int PAGE_BYTES = prcc_pkg::PRCC_PAGE_BYTES,
    parameter int SLOT_BYTES = prcc_pkg::PRCC_SLOT_BYTES,
    parameter int BATCH_MAX  = prcc_pkg::PRCC_BATCH_MAX
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [prcc_pkg::ROW_ID_W-1:0]  i_row_id,
    input  wire logic                           i_batch_end,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [prcc_pkg::OFFSET_W-1:0]       o_byte_offset,
    output logic [prcc_pkg::LENGTH_W-1:0]       o_byte_length,
    output logic [prcc_pkg::POS_W-1:0]          o_first_position,
    output logic [prcc_pkg::COUNT_W-1:0]        o_rows_covered,
    output logic                                o_fits_slot,
    output logic                                o_final_range,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [prcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [prcc_pkg::ROWS_W-1:0]    i_cfg_data
);
    import prcc_pkg::*;

    logic [ROWS_W-1:0]   r_column_rows;
    logic [LENGTH_W-1:0] r_max_range;

    logic   take_in;
    t_span  front_span;
    logic   mid_empty;
    t_span  mid_span;
    logic   back_take;
    logic   out_room2;
    logic   out_wr0, out_wr1;
    t_range rec0, rec1;
    t_range head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_rows <= COLUMN_ROWS_RESET;
            r_max_range   <= MAX_RANGE_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COLUMN_ROWS: r_column_rows <= i_cfg_data;
                CFG_MAX_RANGE:   r_max_range   <= i_cfg_data[LENGTH_W-1:0];
                default: ;  // unknown index: drop
            endcase
        end
    end

    assign take_in = push & ~full;

    prcc_front #(
        .PAGE_BYTES (PAGE_BYTES),
        .BATCH_MAX  (BATCH_MAX)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take_in),
        .i_row_id      (i_row_id),
        .i_batch_end   (i_batch_end),
        .i_column_rows (r_column_rows),
        .o_span        (front_span)
    );

    prcc_fifo #(
        .W     ($bits(t_span)),
        .DEPTH (MID_DEPTH)
    ) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (take_in),
        .i_wr1   (1'b0),
        .i_din0  (front_span),
        .i_din1  ('0),
        .o_full  (full),
        .o_room2 (),
        .i_rd    (back_take),
        .o_empty (mid_empty),
        .o_dout  (mid_span)
    );

    prcc_back #(
        .SLOT_BYTES (SLOT_BYTES),
        .BATCH_MAX  (BATCH_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (~mid_empty),
        .i_span      (mid_span),
        .o_take      (back_take),
        .i_max_range (r_max_range),
        .i_room2     (out_room2),
        .o_wr0       (out_wr0),
        .o_wr1       (out_wr1),
        .o_rec0      (rec0),
        .o_rec1      (rec1)
    );

    prcc_fifo #(
        .W     ($bits(t_range)),
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (out_wr0),
        .i_wr1   (out_wr1),
        .i_din0  (rec0),
        .i_din1  (rec1),
        .o_full  (),
        .o_room2 (out_room2),
        .i_rd    (pop),
        .o_empty (empty),
        .o_dout  (head)
    );

    assign o_byte_offset    = head.byte_offset;
    assign o_byte_length    = head.byte_length;
    assign o_first_position = head.first_position;
    assign o_rows_covered   = head.rows_covered;
    assign o_fits_slot      = head.fits_slot;
    assign o_final_range    = head.final_range;
endmodule
`default_nettype wire

// File: rtl/prcc_fifo.sv
`default_nettype none
module prcc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr0,
    input  wire logic         i_wr1,
    input  wire logic [W-1:0] i_din0,
    input  wire logic [W-1:0] i_din1,
    output logic              o_full,
    output logic              o_room2,
    input  wire logic         i_rd,
    output logic              o_empty,
    output logic [W-1:0]      o_dout
);
    // DEPTH is a power of two so the pointers wrap on their own.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          rd_ok;
    logic [CW-1:0] wr_n;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_room2 = (r_cnt <= CW'(DEPTH - 2));
    assign o_dout  = r_mem[r_rp];
    assign rd_ok   = i_rd & ~o_empty;
    assign wr_n    = CW'(i_wr0) + CW'(i_wr1);

    // The second write lands behind the first; it is used only together with it.
    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_mem[r_wp] <= i_din0;
        end
        if (i_wr1) begin
            r_mem[r_wp + AW'(1)] <= i_din1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(wr_n);
            r_rp  <= r_rp + AW'(rd_ok);
            r_cnt <= r_cnt + wr_n - CW'(rd_ok);
        end
    end
endmodule
`default_nettype wire

// File: rtl/prcc_front.sv
`default_nettype none
module prcc_front #(
    parameter int PAGE_BYTES = 4096,
    parameter int BATCH_MAX  = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_take,
    input  wire logic [prcc_pkg::ROW_ID_W-1:0] i_row_id,
    input  wire logic                          i_batch_end,
    input  wire logic [prcc_pkg::ROWS_W-1:0]   i_column_rows,
    output prcc_pkg::t_span                    o_span
);
    import prcc_pkg::*;

    localparam int BP_W = $clog2(BATCH_MAX);
    localparam logic [BYTE_W-1:0] PAGE_MASK = ~BYTE_W'(PAGE_BYTES - 1);

    logic [BP_W-1:0]     r_pos;
    logic [BP_W-1:0]     n_pos;
    logic [OFFSET_W-1:0] off;
    logic [OFFSET_W-1:0] pbeg;
    logic [BYTE_W-1:0]   pend_raw;
    logic [BYTE_W-1:0]   pend_clip;
    logic [BYTE_W-1:0]   col_limit;
    logic                last;

    assign off       = {i_row_id, 3'b000};
    assign pbeg      = off & OFFSET_W'(PAGE_MASK);
    assign pend_raw  = (BYTE_W'(off) + BYTE_W'(8 + PAGE_BYTES - 1)) & PAGE_MASK;
    assign col_limit = {i_column_rows, 3'b000};

    // Clip at the column end; a row past the end becomes an empty span.
    always_comb begin
        pend_clip = (pend_raw > col_limit) ? col_limit : pend_raw;
        if (pend_clip < BYTE_W'(pbeg)) begin
            pend_clip = BYTE_W'(pbeg);
        end
    end

    // An overlong batch is cut at its last allowed position.
    assign last  = i_batch_end | (r_pos == BP_W'(BATCH_MAX - 1));
    assign n_pos = last ? '0 : r_pos + BP_W'(1);

    always_comb begin
        o_span.pbeg = pbeg;
        o_span.pend = pend_clip;
        o_span.pos  = POS_W'(r_pos);
        o_span.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_take) begin
            r_pos <= n_pos;
        end
    end
endmodule
`default_nettype wire

// File: rtl/prcc_back.sv
`default_nettype none
module prcc_back #(
    parameter int SLOT_BYTES = 65536,
    parameter int BATCH_MAX  = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire prcc_pkg::t_span               i_span,
    output logic                               o_take,
    input  wire logic [prcc_pkg::LENGTH_W-1:0] i_max_range,
    input  wire logic                          i_room2,
    output logic                               o_wr0,
    output logic                               o_wr1,
    output prcc_pkg::t_range                   o_rec0,
    output prcc_pkg::t_range                   o_rec1
);
    import prcc_pkg::*;

    localparam int CNT_W = $clog2(BATCH_MAX + 1);

    logic                r_open;
    logic [OFFSET_W-1:0] r_off;
    logic [LENGTH_W-1:0] r_len;
    logic [BYTE_W-1:0]   r_end;
    logic [POS_W-1:0]    r_first;
    logic [CNT_W-1:0]    r_cnt;

    logic [OFFSET_W-1:0] n_off;
    logic [LENGTH_W-1:0] n_len;
    logic [BYTE_W-1:0]   n_end;
    logic [POS_W-1:0]    n_first;
    logic [CNT_W-1:0]    n_cnt;

    logic [BYTE_W:0]     diff;
    logic                merge;
    logic                closed;
    t_range              rec_closed;
    t_range              rec_flush;

    assign o_take = i_valid & i_room2;

    // Span end relative to the open start; the top bit is the borrow.
    assign diff  = {1'b0, i_span.pend} - {2'b00, r_off};
    assign merge = r_open & (BYTE_W'(i_span.pbeg) <= r_end) & ~diff[BYTE_W]
                 & (diff[BYTE_W-1:0] <= BYTE_W'(i_max_range));
    assign closed = r_open & ~merge;

    always_comb begin
        if (merge) begin
            n_off   = r_off;
            n_first = r_first;
            n_cnt   = r_cnt + CNT_W'(1);
            if (i_span.pend > r_end) begin
                n_len = diff[LENGTH_W-1:0];
                n_end = i_span.pend;
            end else begin
                n_len = r_len;
                n_end = r_end;
            end
        end else begin
            n_off   = i_span.pbeg;
            n_len   = LENGTH_W'(i_span.pend - BYTE_W'(i_span.pbeg));
            n_end   = i_span.pend;
            n_first = i_span.pos;
            n_cnt   = CNT_W'(1);
        end
    end

    always_comb begin
        rec_closed.byte_offset    = r_off;
        rec_closed.byte_length    = r_len;
        rec_closed.first_position = r_first;
        rec_closed.rows_covered   = COUNT_W'(r_cnt);
        rec_closed.fits_slot      = (r_len <= LENGTH_W'(SLOT_BYTES));
        rec_closed.final_range    = 1'b0;

        rec_flush.byte_offset     = n_off;
        rec_flush.byte_length     = n_len;
        rec_flush.first_position  = n_first;
        rec_flush.rows_covered    = COUNT_W'(n_cnt);
        rec_flush.fits_slot       = (n_len <= LENGTH_W'(SLOT_BYTES));
        rec_flush.final_range     = 1'b1;
    end

    // The closed range goes ahead of the flushed one.
    assign o_wr0  = o_take & (closed | i_span.last);
    assign o_wr1  = o_take & closed & i_span.last;
    assign o_rec0 = closed ? rec_closed : rec_flush;
    assign o_rec1 = rec_flush;

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_off   <= n_off;
            r_len   <= n_len;
            r_end   <= n_end;
            r_first <= n_first;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (o_take) begin
            r_open <= ~i_span.last;
        end
    end
endmodule
`default_nettype wire
